### src/isbrs_pkg.sv
// ---------------------------------------------------------------------------
// isbrs_pkg: shared types and constants for the sensor burst-read sequencer
// Status codes, controller actions, register indexes and payload structs.
// ---------------------------------------------------------------------------
`default_nettype none

package isbrs_pkg;

	// TWI master status codes, low three bits dropped (status[7:3])
	localparam logic [4:0] TWI_START      = 5'h01; // 0x08
	localparam logic [4:0] TWI_RESTART    = 5'h02; // 0x10
	localparam logic [4:0] TWI_SLA_W_ACK  = 5'h03; // 0x18
	localparam logic [4:0] TWI_DATA_W_ACK = 5'h05; // 0x28
	localparam logic [4:0] TWI_SLA_R_ACK  = 5'h08; // 0x40
	localparam logic [4:0] TWI_DATA_R_ACK = 5'h0A; // 0x50
	localparam logic [4:0] TWI_DATA_R_NAK = 5'h0B; // 0x58

	localparam logic [15:0] HEADING_ERR  = 16'hEEEE;
	localparam logic [7:0]  ANGLE_ERR    = 8'hBB;
	localparam logic [15:0] HEADING_NONE = 16'hFFFF;
	localparam logic [7:0]  ANGLE_NONE   = 8'hFF;

	typedef enum logic [2:0] {
		ACT_NONE  = 3'd0,
		ACT_NACK  = 3'd1,
		ACT_ACK   = 3'd2,
		ACT_START = 3'd3,
		ACT_STOP  = 3'd4,
		ACT_ABORT = 3'd5
	} act_t;

	typedef enum logic [1:0] {
		REG_DEVICE_ADDRESS = 2'd0,
		REG_FIRST_REGISTER = 2'd1,
		REG_ENABLE         = 2'd2
	} reg_idx_t;

	localparam logic CMD_START  = 1'b0;
	localparam logic CMD_STATUS = 1'b1;

	typedef struct packed {
		logic       command;
		logic [7:0] status;
		logic [7:0] rx_byte;
	} isbrs_in_t;

	typedef struct packed {
		logic [2:0]  action;
		logic        tx_valid;
		logic [7:0]  tx_byte;
		logic [15:0] heading_value;
		logic        heading_valid;
		logic [7:0]  pitch_value;
		logic        pitch_valid;
		logic [7:0]  roll_value;
		logic        roll_valid;
		logic        busy_res;
		logic        fault;
	} isbrs_out_t;

	typedef struct packed {
		logic [6:0] device_address;
		logic [7:0] first_register;
		logic       enable;
	} isbrs_cfg_t;

endpackage

`default_nettype wire

### src/isbrs_cfg.sv
// ---------------------------------------------------------------------------
// isbrs_cfg: configuration registers
// Device address, first register and enable, written by index.
// ---------------------------------------------------------------------------
`default_nettype none

module isbrs_cfg import isbrs_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data,
	output isbrs_cfg_t      cfg
);

	isbrs_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_address <= 7'd96;
			cfg_q.first_register <= 8'd2;
			cfg_q.enable         <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEVICE_ADDRESS: cfg_q.device_address <= cfg_data[6:0];
				REG_FIRST_REGISTER: cfg_q.first_register <= cfg_data;
				REG_ENABLE:         cfg_q.enable         <= cfg_data[0];
				default: ; // unused index
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

### src/isbrs_core.sv
// ---------------------------------------------------------------------------
// isbrs_core: sequencer state and next-state logic
// Decodes one beat against the current state, updates state on step.
// ---------------------------------------------------------------------------
`default_nettype none

module isbrs_core import isbrs_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire isbrs_in_t  item,
	input  wire isbrs_cfg_t cfg,
	output isbrs_out_t      res
);

	logic [1:0]  phase_q, phase_d;
	logic [15:0] heading_q, heading_d;
	logic [7:0]  pitch_q, pitch_d;
	logic [7:0]  roll_q, roll_d;
	logic [2:0]  ready_q, ready_d;
	logic        active_q, active_d;
	logic        error_q, error_d;
	act_t        act;
	logic        txv;
	logic [7:0]  txb;

	always_comb begin
		phase_d   = phase_q;
		heading_d = heading_q;
		pitch_d   = pitch_q;
		roll_d    = roll_q;
		ready_d   = ready_q;
		active_d  = active_q;
		error_d   = error_q;
		act       = ACT_NONE;
		txv       = 1'b0;
		txb       = 8'h00;
		if (item.command == CMD_START) begin
			if (!active_q) begin
				phase_d   = 2'd0;
				heading_d = HEADING_NONE;
				pitch_d   = ANGLE_NONE;
				roll_d    = ANGLE_NONE;
				ready_d   = 3'b000;
				error_d   = 1'b0;
				active_d  = 1'b1;
				if (cfg.enable) act = ACT_START;
			end
		end else begin
			unique case (item.status[7:3])
				TWI_START: begin
					txv = 1'b1;
					txb = {cfg.device_address, 1'b0};
					act = ACT_NACK;
				end
				TWI_SLA_W_ACK: begin
					txv = 1'b1;
					txb = cfg.first_register;
					act = ACT_NACK;
				end
				TWI_DATA_W_ACK: act = ACT_START;
				TWI_RESTART: begin
					txv = 1'b1;
					txb = {cfg.device_address, 1'b1};
					act = ACT_NACK;
				end
				TWI_SLA_R_ACK: begin
					if (phase_q == 2'd0) act = ACT_ACK;
				end
				TWI_DATA_R_ACK: begin
					unique case (phase_q)
						2'd0: begin
							heading_d = {item.rx_byte, 8'h00};
							phase_d   = 2'd1;
							act       = ACT_ACK;
						end
						2'd1: begin
							heading_d  = heading_q | {8'h00, item.rx_byte};
							ready_d[0] = 1'b1;
							phase_d    = 2'd2;
							act        = ACT_ACK;
						end
						2'd2: begin
							pitch_d    = item.rx_byte;
							ready_d[1] = 1'b1;
							phase_d    = 2'd3;
							act        = ACT_NACK;
						end
						default: act = ACT_ACK; // roll phase: nothing captured
					endcase
				end
				TWI_DATA_R_NAK: begin
					if (phase_q == 2'd3) begin
						roll_d     = item.rx_byte;
						ready_d[2] = 1'b1;
						active_d   = 1'b0;
						act        = ACT_STOP;
					end else begin
						error_d   = 1'b1;
						heading_d = HEADING_ERR;
						active_d  = 1'b0;
						act       = ACT_ABORT;
					end
				end
				default: begin
					error_d   = 1'b1;
					heading_d = HEADING_ERR;
					pitch_d   = ANGLE_ERR;
					roll_d    = ANGLE_ERR;
					active_d  = 1'b0;
					act       = ACT_ABORT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= 2'd0;
			heading_q <= 16'h0000;
			pitch_q   <= 8'h00;
			roll_q    <= 8'h00;
			ready_q   <= 3'b000;
			active_q  <= 1'b0;
			error_q   <= 1'b0;
		end else if (step) begin
			phase_q   <= phase_d;
			heading_q <= heading_d;
			pitch_q   <= pitch_d;
			roll_q    <= roll_d;
			ready_q   <= ready_d;
			active_q  <= active_d;
			error_q   <= error_d;
		end
	end

	always_comb begin
		res.action        = act;
		res.tx_valid      = txv;
		res.tx_byte       = txb;
		res.heading_value = heading_d;
		res.heading_valid = ready_d[0];
		res.pitch_value   = pitch_d;
		res.pitch_valid   = ready_d[1];
		res.roll_value    = roll_d;
		res.roll_valid    = ready_d[2];
		res.busy_res      = active_d;
		res.fault         = error_d;
	end

endmodule

`default_nettype wire

### src/i2c_sensor_burst_read_sequencer_unit.sv
// A beat is held in the request register, then decoded and shown on rsp from the result
// register. Throughput: one beat per cycle while rsp is not stalled; the decode is a
// single pass between the request and result registers, state updated in the same edge.
// A stalled result holds; the request register then fills only while it is empty.
// Reset (arst_n low, asynchronous): both registers empty, state and flags cleared,
// configuration back to address 96, first register 2, disabled.
// ---------------------------------------------------------------------------
// i2c_sensor_burst_read_sequencer_unit: I2C sensor burst-read sequencer
// Takes start commands and bus status beats, returns the controller action,
// the byte to send and the current heading, pitch and roll readings.
// ---------------------------------------------------------------------------
`default_nettype none

module i2c_sensor_burst_read_sequencer_unit import isbrs_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// request channel
	input  wire logic       req_valid,
	output logic            req_stall,
	input  wire isbrs_in_t  req,
	// result channel
	output logic            rsp_valid,
	input  wire logic       rsp_stall,
	output isbrs_out_t      rsp,
	// configuration write port
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data
);

	isbrs_cfg_t cfg;
	isbrs_out_t res;

	// request register
	logic       req_valid_s1;
	isbrs_in_t  req_s1;
	// result register
	logic       rsp_valid_s2;
	isbrs_out_t rsp_s2;

	logic advance;

	// The beat in the request register moves on whenever the result register
	// is empty or is being drained this cycle.
	assign advance   = req_valid_s1 && (!rsp_valid_s2 || !rsp_stall);
	assign req_stall = req_valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			req_valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
	end

	isbrs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// State commits only when the result is actually captured.
	isbrs_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (req_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_s2 <= 1'b0;
		end else if (advance) begin
			rsp_valid_s2 <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_s2 <= res;
		end
	end

	assign rsp_valid = rsp_valid_s2;
	assign rsp       = rsp_s2;

`ifndef SYNTHESIS
	// A read that ends in error is never still marked in progress.
	a_busy_fault: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.busy_res && rsp.fault))
		else $error("busy and fault both set");

	// Bytes to send only go out with a plain continue.
	a_tx_action: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.tx_valid) |-> (rsp.action == ACT_NACK))
		else $error("tx byte without continue action");

	// A clean STOP completes all three readings and ends the transaction.
	a_stop_done: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.action == ACT_STOP) |->
		(rsp.roll_valid && rsp.pitch_valid && rsp.heading_valid && !rsp.busy_res))
		else $error("stop without complete readings");

	// Abort always leaves the error marker on the heading.
	a_abort_marker: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.action == ACT_ABORT) |->
		(rsp.fault && rsp.heading_value == HEADING_ERR))
		else $error("abort without error markers");

	// Request side is only held off when a beat is waiting on a full result stage.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (req_valid_s1 && rsp_valid_s2 && rsp_stall))
		else $error("request stalled without cause");
`endif

endmodule

`default_nettype wire
